/* rtl/cpf_pkg.sv */
// Shared types, constants and the CRC-8 function of the packet framer.
package cpf_pkg;

  localparam int unsigned FifoDepth = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_END_MARKER  = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hFA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hFB;
  localparam logic [7:0] END_MARKER_RST  = 8'hFB;

  localparam logic [7:0]  CRC_POLY  = 8'h07;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Phases of one frame segment on the output side
  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_LENLO = 3'd1;
  localparam logic [2:0] PH_LENHI = 3'd2;
  localparam logic [2:0] PH_HCRC  = 3'd3;
  localparam logic [2:0] PH_SYNC2 = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_PCRC  = 3'd6;
  localparam logic [2:0] PH_END   = 3'd7;

  // One queued command: which frame segments to emit and their contents
  typedef struct packed {
    logic        hdr;   // emit the five header bytes
    logic [15:0] len;
    logic [7:0]  hcrc;
    logic        pay;   // emit one payload byte
    logic [7:0]  data;
    logic        trl;   // emit payload CRC and end marker
    logic [7:0]  pcrc;
    logic        mis;
  } cmd_t;

  // CRC-8, polynomial 0x07, MSB first
  function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* rtl/cpf_front.sv */
// Front end: accepts input transactions, tracks frame state and builds commands.
module cpf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       payload_byte_i,
  input  logic             first_byte_i,
  input  logic             last_byte_i,
  input  logic [15:0]      declared_length_i,
  input  logic [7:0]       sync_first_i,
  input  logic             full_i,
  output logic             push_o,
  output cpf_pkg::cmd_t    cmd_o
);

  logic        in_frame_q, in_frame_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] count_q, count_d;
  logic [15:0] exp_q, exp_d;
  logic        over_q, over_d;

  logic        acc;
  logic [7:0]  data_crc;
  logic [15:0] count_base, count_n;
  logic        over_n;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign push_o     = acc && (first_byte_i || in_frame_q);

  always_comb begin
    data_crc   = cpf_pkg::crc8(first_byte_i ? 8'h00 : crc_q, payload_byte_i);
    count_base = first_byte_i ? 16'h0000 : count_q;
    if (count_base == cpf_pkg::COUNT_MAX) begin
      count_n = count_base;
      over_n  = 1'b1;
    end else begin
      count_n = count_base + 16'd1;
      over_n  = first_byte_i ? 1'b0 : over_q;
    end

    cmd_o.hdr  = first_byte_i;
    cmd_o.len  = declared_length_i;
    cmd_o.hcrc = cpf_pkg::crc8(cpf_pkg::crc8(cpf_pkg::crc8(8'h00, sync_first_i),
                 declared_length_i[7:0]), declared_length_i[15:8]);
    cmd_o.pay  = first_byte_i ? (declared_length_i != 16'h0000) : 1'b1;
    cmd_o.data = payload_byte_i;
    cmd_o.trl  = first_byte_i ? (declared_length_i == 16'h0000) : last_byte_i;
    cmd_o.pcrc = first_byte_i ? 8'h00 : data_crc;
    cmd_o.mis  = !first_byte_i && (over_n || (count_n != exp_q));

    in_frame_d = in_frame_q;
    crc_d      = crc_q;
    count_d    = count_q;
    exp_d      = exp_q;
    over_d     = over_q;
    if (acc && first_byte_i) begin
      exp_d      = declared_length_i;
      in_frame_d = (declared_length_i != 16'h0000);
      crc_d      = data_crc;
      count_d    = count_n;
      over_d     = over_n;
    end else if (acc && in_frame_q) begin
      crc_d   = data_crc;
      count_d = count_n;
      over_d  = over_n;
      if (last_byte_i) begin
        in_frame_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      crc_q      <= 8'h00;
      count_q    <= 16'h0000;
      exp_q      <= 16'h0000;
      over_q     <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      crc_q      <= crc_d;
      count_q    <= count_d;
      exp_q      <= exp_d;
      over_q     <= over_d;
    end
  end

endmodule

/* rtl/cpf_fifo.sv */
// Small command queue between the front end and the byte sequencer.
module cpf_fifo #(
  parameter int unsigned Depth = cpf_pkg::FifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cpf_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output cpf_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cpf_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/cpf_back.sv */
// Back end: walks each queued command byte by byte into the output register.
module cpf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cpf_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  input  logic [7:0]    sync_first_i,
  input  logic [7:0]    sync_second_i,
  input  logic [7:0]    end_marker_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          run_last_o,
  output logic          frame_done_o,
  output logic          length_mismatch_o
);

  logic       busy_q;
  logic [2:0] phase_q;
  logic [2:0] ph, ph_next;
  logic [7:0] byte_sel;
  logic       seg_last, load;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_last_q, done_q, mis_q;

  always_comb begin
    ph = busy_q ? phase_q : (cmd_i.hdr ? cpf_pkg::PH_SYNC1 : cpf_pkg::PH_DATA);
    case (ph)
      cpf_pkg::PH_SYNC1: byte_sel = sync_first_i;
      cpf_pkg::PH_LENLO: byte_sel = cmd_i.len[7:0];
      cpf_pkg::PH_LENHI: byte_sel = cmd_i.len[15:8];
      cpf_pkg::PH_HCRC:  byte_sel = cmd_i.hcrc;
      cpf_pkg::PH_SYNC2: byte_sel = sync_second_i;
      cpf_pkg::PH_DATA:  byte_sel = cmd_i.data;
      cpf_pkg::PH_PCRC:  byte_sel = cmd_i.pcrc;
      default:           byte_sel = end_marker_i;
    endcase
    case (ph)
      cpf_pkg::PH_SYNC2: ph_next = cmd_i.pay ? cpf_pkg::PH_DATA : cpf_pkg::PH_PCRC;
      cpf_pkg::PH_DATA:  ph_next = cpf_pkg::PH_PCRC;
      default:           ph_next = ph + 3'd1;
    endcase
    seg_last = (ph == cpf_pkg::PH_END) || ((ph == cpf_pkg::PH_DATA) && !cmd_i.trl);
  end

  assign load  = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && seg_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= cpf_pkg::PH_SYNC1;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q      <= !seg_last;
        phase_q     <= ph_next;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_sel;
      run_last_q <= seg_last;
      done_q     <= (ph == cpf_pkg::PH_END);
      mis_q      <= (ph == cpf_pkg::PH_END) && cmd_i.mis;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign run_last_o        = run_last_q;
  assign frame_done_o      = done_q;
  assign length_mismatch_o = mis_q;

endmodule

/* rtl/crc8_packet_framer_core.sv */
// Top level of the CRC-8 packet framer: config registers, front end, queue, sequencer.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------------
//  in       | in_valid_i / in_ready_o | payload_byte, first_byte, last_byte, declared_length
//  out      | out_valid_o/out_ready_i | out_byte, run_last, frame_done, length_mismatch
//  cfg      | cfg_we_i (no stall)     | cfg_idx_i, cfg_wdata_i
//
// An input transaction is taken whenever the command queue has room; the front end
// updates the running CRC and byte count in the same cycle. The output side emits
// one byte per cycle while out_ready_i is high: a payload-only transaction gives one
// byte, a frame opener five extra header bytes, a closer two extra trailer bytes.
// With no output stall, mid-frame sustains one transaction per cycle; header and trailer
// bursts drain from the queue (FifoDepth commands deep) while input keeps flowing.
// Reset clears frame state, queue pointers and the output valid; no clearing pass.
// A stalled output holds its register; the queue fills and then drops in_ready_o.
module crc8_packet_framer_core #(
  parameter int unsigned FifoDepth = cpf_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  payload_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] declared_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        frame_done_o,
  output logic        length_mismatch_o
);

  logic [7:0] sync_first_q, sync_second_q, end_marker_q;

  cpf_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, full, empty;

  // Hold configuration; write it only while no transaction is in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= cpf_pkg::SYNC_FIRST_RST;
      sync_second_q <= cpf_pkg::SYNC_SECOND_RST;
      end_marker_q  <= cpf_pkg::END_MARKER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpf_pkg::REG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i;
        cpf_pkg::REG_SYNC_SECOND: sync_second_q <= cfg_wdata_i;
        cpf_pkg::REG_END_MARKER:  end_marker_q  <= cfg_wdata_i;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Classify each transaction and compute header CRC, payload CRC and mismatch.
  cpf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .payload_byte_i    (payload_byte_i),
    .first_byte_i      (first_byte_i),
    .last_byte_i       (last_byte_i),
    .declared_length_i (declared_length_i),
    .sync_first_i      (sync_first_q),
    .full_i            (full),
    .push_o            (push),
    .cmd_o             (push_cmd)
  );

  // Decouple the front end, which builds each command combinationally, from the multi-byte output bursts.
  cpf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  // Serialize the head command into the registered output.
  cpf_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (head_cmd),
    .empty_i           (empty),
    .pop_o             (pop),
    .sync_first_i      (sync_first_q),
    .sync_second_i     (sync_second_q),
    .end_marker_i      (end_marker_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .run_last_o        (run_last_o),
    .frame_done_o      (frame_done_o),
    .length_mismatch_o (length_mismatch_o)
  );

endmodule

/* rtl/cpf_checker.sv */
// Port-level assertions for the packet framer and their bind to the top level.
module cpf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       frame_done_o,
  input logic       length_mismatch_o
);

  // End marker always closes the transaction's burst.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> run_last_o)
    else $error("frame_done without run_last");

  // Mismatch flag appears only on the end marker.
  a_mis_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_mismatch_o |-> frame_done_o)
    else $error("length_mismatch off the end marker");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid dropped while stalled");

  a_byte_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_byte_o))
    else $error("out_byte changed while stalled");

endmodule

bind crc8_packet_framer_core cpf_checker u_cpf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .out_byte_o        (out_byte_o),
  .run_last_o        (run_last_o),
  .frame_done_o      (frame_done_o),
  .length_mismatch_o (length_mismatch_o)
);

/* bench/tb_top.sv */
// Self-checking bench for the CRC-8 packet framer: predicts every frame byte and scores it.
module tb_top;

  // Quiet-cycle limit: the slowest correct stretch is a sender gap, a sink stall, or
  // the settle and register-write pause; this is far beyond any of them.
  localparam int StallLimit = 3000;
  // Cycles to let the core settle once nothing is owed: covers the command queue,
  // the header sequencer and the output register, with margin.
  localparam int SettleCycles = 24;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] len;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       done;
    logic       mis;
  } frame_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  payload_byte_i;
  logic        first_byte_i;
  logic        last_byte_i;
  logic [15:0] declared_length_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        frame_done_o;
  logic        length_mismatch_o;

  crc8_packet_framer_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .payload_byte_i   (payload_byte_i),
    .first_byte_i     (first_byte_i),
    .last_byte_i      (last_byte_i),
    .declared_length_i(declared_length_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .run_last_o       (run_last_o),
    .frame_done_o     (frame_done_o),
    .length_mismatch_o(length_mismatch_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus waiting to be sent, and frame bytes the core still owes us.
  byte_item_t  pending_bytes[$];
  frame_byte_t frame_bytes_due[$];

  int   errors = 0;
  logic in_taken = 1'b0;
  logic src_idle_en = 1'b0;
  logic snk_idle_en = 1'b0;
  int   src_gap = 0;
  int   snk_stall = 0;
  int   quiet_cycles = 0;

  // Shadow copy of the configuration registers.
  logic [7:0] cfg_sync1 = cpf_pkg::SYNC_FIRST_RST;
  logic [7:0] cfg_sync2 = cpf_pkg::SYNC_SECOND_RST;
  logic [7:0] cfg_endm  = cpf_pkg::END_MARKER_RST;

  // Shadow frame state: running payload CRC, saturating byte count, header length.
  logic [7:0]  pay_crc = 8'h00;
  logic [15:0] pay_count = 16'h0000;
  logic [15:0] want_len = 16'h0000;
  logic        framing = 1'b0;
  logic        count_sat = 1'b0;

  // Serial CRC-8, one message bit per step, MSB first.
  function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] din);
    logic [7:0] r;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      if (r[7] ^ din[k]) begin
        r = {r[6:0], 1'b0} ^ cpf_pkg::CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic void push_byte(logic [7:0] b, logic done, logic mis);
    frame_byte_t fb;
    fb = '{data: b, run_last: 1'b0, done: done, mis: mis};
    frame_bytes_due = {frame_bytes_due, fb};
  endfunction

  // One payload byte goes out and into the running CRC; the count saturates.
  function automatic void absorb_payload(logic [7:0] b);
    push_byte(b, 1'b0, 1'b0);
    pay_crc = crc8_next(pay_crc, b);
    if (pay_count == cpf_pkg::COUNT_MAX) begin
      count_sat = 1'b1;
    end else begin
      pay_count = pay_count + 16'd1;
    end
  endfunction

  // Trailer: payload CRC, then the end marker carrying the length check.
  function automatic void close_frame_out();
    push_byte(pay_crc, 1'b0, 1'b0);
    push_byte(cfg_endm, 1'b1, count_sat || (pay_count != want_len));
    framing = 1'b0;
  endfunction

  function automatic void add_item(logic [7:0] d, logic f, logic l, logic [15:0] n);
    byte_item_t it;
    it = '{data: d, first: f, last: l, len: n};
    pending_bytes = {pending_bytes, it};
  endfunction

  // Predict first, then score: the prediction for a transaction is queued at its
  // accepting edge, before any byte it causes can show up on the output.
  always @(posedge clk_i) begin
    logic [7:0]  hcrc;
    int          owed_before;
    frame_byte_t want;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cpf_pkg::REG_SYNC_FIRST:  cfg_sync1 = cfg_wdata_i;
          cpf_pkg::REG_SYNC_SECOND: cfg_sync2 = cfg_wdata_i;
          cpf_pkg::REG_END_MARKER:  cfg_endm  = cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_o) begin
        owed_before = frame_bytes_due.size();
        if (first_byte_i) begin
          // Open a frame (abandoning any open one without trailer).
          hcrc = crc8_next(crc8_next(crc8_next(8'h00, cfg_sync1),
                                     declared_length_i[7:0]), declared_length_i[15:8]);
          push_byte(cfg_sync1, 1'b0, 1'b0);
          push_byte(declared_length_i[7:0], 1'b0, 1'b0);
          push_byte(declared_length_i[15:8], 1'b0, 1'b0);
          push_byte(hcrc, 1'b0, 1'b0);
          push_byte(cfg_sync2, 1'b0, 1'b0);
          pay_crc   = 8'h00;
          pay_count = 16'h0000;
          count_sat = 1'b0;
          want_len  = declared_length_i;
          framing   = 1'b1;
          // Zero length closes at once; otherwise last is ignored on the opener.
          if (declared_length_i == 16'h0000) begin
            close_frame_out();
          end else begin
            absorb_payload(payload_byte_i);
          end
        end else if (framing) begin
          absorb_payload(payload_byte_i);
          if (last_byte_i) begin
            close_frame_out();
          end
        end
        // Flag the final byte of this transaction; a stray byte outside a frame owes nothing.
        if (frame_bytes_due.size() > owed_before) begin
          frame_bytes_due[frame_bytes_due.size() - 1].run_last = 1'b1;
        end
      end

      if (out_valid_o && out_ready_i) begin
        if (frame_bytes_due.size() == 0) begin
          $error("unexpected output transaction: out_byte %h", out_byte_o);
          errors++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_byte_o !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte_o);
            errors++;
          end
          if (run_last_o !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, run_last_o);
            errors++;
          end
          if (frame_done_o !== want.done) begin
            $error("frame_done: expected %b, got %b", want.done, frame_done_o);
            errors++;
          end
          if (length_mismatch_o !== want.mis) begin
            $error("length_mismatch: expected %b, got %b", want.mis, length_mismatch_o);
            errors++;
          end
        end
      end
    end
  end

  // Sender: advance to the next item once the current one is taken; hold valid
  // and payload steady until then. Gaps start only between transactions.
  always @(negedge clk_i) begin
    byte_item_t nxt;
    if (in_taken || !in_valid_i) begin
      if (in_taken && src_idle_en && $urandom_range(0, 3) == 0) begin
        src_gap = $urandom_range(1, 11);
      end
      if (src_gap > 0) begin
        src_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        payload_byte_i    <= nxt.data;
        first_byte_i      <= nxt.first;
        last_byte_i       <= nxt.last;
        declared_length_i <= nxt.len;
        in_valid_i        <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: drop ready in random bursts while enabled.
  always @(negedge clk_i) begin
    if (snk_stall > 0) begin
      snk_stall--;
      out_ready_i <= 1'b0;
    end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
      snk_stall = $urandom_range(1, 11) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == StallLimit) begin
      $error("timeout: %0d items unsent, %0d frame bytes outstanding",
             pending_bytes.size(), frame_bytes_due.size());
      $display("crc8_packet_framer_core regression: fail");
      $finish;
    end
  end

  // Hold until everything sent is answered and the core has gone quiet.
  task automatic wait_idle();
    int settle;
    settle = 0;
    while (settle < SettleCycles) begin
      @(negedge clk_i);
      if (pending_bytes.size() != 0 || in_valid_i || frame_bytes_due.size() != 0) begin
        settle = 0;
      end else begin
        settle++;
      end
    end
  endtask

  task automatic write_regs(input logic [7:0] s1, input logic [7:0] s2,
                            input logic [7:0] em);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= cpf_pkg::REG_SYNC_FIRST;
    cfg_wdata_i <= s1;
    @(negedge clk_i);
    cfg_idx_i   <= cpf_pkg::REG_SYNC_SECOND;
    cfg_wdata_i <= s2;
    @(negedge clk_i);
    cfg_idx_i   <= cpf_pkg::REG_END_MARKER;
    cfg_wdata_i <= em;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed frames with random content; the rest are stray bytes,
  // empty frames, frames left open and frames whose header length is wrong.
  task automatic gen_frames(input int target);
    int          made;
    int          kind;
    int          n;
    logic [15:0] decl;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        add_item(8'($urandom), 1'b0, 1'($urandom), 16'($urandom));
      end else if (kind < 14) begin
        add_item(8'($urandom), 1'b1, 1'($urandom), 16'h0000);
        made++;
      end else begin
        n = (kind < 20) ? $urandom_range(2, 40) : $urandom_range(2, 10);
        decl = 16'(n);
        if (kind < 34) begin
          decl = 16'($urandom);
        end else if (kind < 42) begin
          decl = 16'(n + 2 * int'($urandom_range(0, 1)) - 1);
        end
        add_item(8'($urandom), 1'b1, 1'($urandom), decl);
        // Frames picked below 22 are left open: a later opener abandons them.
        for (int k = 1; k < n; k++) begin
          add_item(8'($urandom), 1'b0, (k == n - 1) && (kind >= 22), 16'($urandom));
        end
        made += n;
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = cpf_pkg::REG_SYNC_FIRST;
    cfg_wdata_i       = 8'h00;
    in_valid_i        = 1'b0;
    payload_byte_i    = 8'h00;
    first_byte_i      = 1'b0;
    last_byte_i       = 1'b0;
    declared_length_i = 16'h0000;
    out_ready_i       = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under reset register values, with idling on both sides.
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    add_item(8'h5A, 1'b0, 1'b1, 16'hFFFF);  // stray byte before any frame
    add_item(8'hFF, 1'b1, 1'b1, 16'h0000);  // empty frame, payload and last ignored
    add_item(8'h00, 1'b1, 1'b0, 16'h0000);  // empty frame, last low
    add_item(8'h00, 1'b1, 1'b1, 16'h0001);  // first and last together: stays open
    add_item(8'hFF, 1'b0, 1'b1, 16'hFFFF);  // closes with two bytes against one
    add_item(8'h80, 1'b1, 1'b0, 16'hFFFF);  // largest header length
    add_item(8'h01, 1'b0, 1'b0, 16'h0000);
    add_item(8'h7F, 1'b0, 1'b1, 16'h0000);
    add_item(8'hAA, 1'b1, 1'b0, 16'h0003);  // length matches the count
    add_item(8'h55, 1'b0, 1'b0, 16'hFFFF);
    add_item(8'hC3, 1'b0, 1'b1, 16'h5555);
    add_item(8'h11, 1'b1, 1'b0, 16'h0100);  // opens a frame that the next opener abandons
    add_item(8'h22, 1'b0, 1'b0, 16'h0000);
    add_item(8'h33, 1'b1, 1'b0, 16'h0002);
    add_item(8'h44, 1'b0, 1'b1, 16'h0000);
    add_item(8'hEE, 1'b0, 1'b1, 16'h8000);  // stray last outside a frame
    add_item(8'h01, 1'b1, 1'b1, 16'h00FF);
    add_item(8'h02, 1'b0, 1'b1, 16'h0000);
    add_item(8'h03, 1'b1, 1'b0, 16'hFF00);
    add_item(8'h04, 1'b0, 1'b1, 16'hAAAA);
    wait_idle();

    // Sync one and end marker at 00, sync two at FF; halfway, stop sending until all is answered.
    write_regs(8'h00, 8'hFF, 8'h00);
    gen_frames(55);
    wait_idle();
    gen_frames(55);
    wait_idle();

    // Sync one and end marker at FF, sync two at 00; receiver stalls only.
    write_regs(8'hFF, 8'h00, 8'hFF);
    src_idle_en = 1'b0;
    gen_frames(105);
    wait_idle();

    // Random markers, sender gaps only.
    write_regs(8'($urandom), 8'($urandom), 8'($urandom));
    src_idle_en = 1'b1;
    snk_idle_en = 1'b0;
    gen_frames(100);
    wait_idle();

    // Last part runs without idling on either side.
    write_regs(8'($urandom), 8'($urandom), 8'($urandom));
    src_idle_en = 1'b0;
    gen_frames(100);
    wait_idle();

    if (errors == 0) begin
      $display("crc8_packet_framer_core regression: pass");
    end else begin
      $display("crc8_packet_framer_core regression: fail");
    end
    $finish;
  end

endmodule
